>>> rtl/wfic_pkg.sv
// Package for the weighted four-index contraction block.
// Holds sizes, command, register and result-kind codes, the sequencer state type and a clamp helper.
// No dependencies.
package wfic_pkg;

    localparam int MAX_EXTENT = 8;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 4 * IDX_W;
    localparam int DEPTH      = MAX_EXTENT ** 4;
    localparam int WGT_W      = 17;
    localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;

    // Commands
    localparam logic [2:0] CMD_WGT_P  = 3'd0;
    localparam logic [2:0] CMD_WGT_Q  = 3'd1;
    localparam logic [2:0] CMD_WR_A   = 3'd2;
    localparam logic [2:0] CMD_WR_B   = 3'd3;
    localparam logic [2:0] CMD_WR_C   = 3'd4;
    localparam logic [2:0] CMD_RUN    = 3'd5;
    localparam logic [2:0] CMD_RD_C   = 3'd6;

    // Register indexes
    localparam logic [2:0] REG_P_EXT  = 3'd0;
    localparam logic [2:0] REG_Q_EXT  = 3'd1;
    localparam logic [2:0] REG_E1     = 3'd2;
    localparam logic [2:0] REG_E2     = 3'd3;
    localparam logic [2:0] REG_E3     = 3'd4;
    localparam logic [2:0] REG_E4     = 3'd5;
    localparam logic [2:0] REG_SCALE  = 3'd6;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDC,
        ST_EMIT,
        ST_T_RD,
        ST_T_W,
        ST_T_X,
        ST_T_XR,
        ST_T_LO,
        ST_T_HI,
        ST_T_ACC,
        ST_T_SUM,
        ST_F_HI,
        ST_F_LO,
        ST_F_MAG,
        ST_F_WR
    } t_state;

    // Clamp an extent to MAX_EXTENT and return its last index
    function automatic logic [IDX_W-1:0] last_idx(input logic [3:0] e);
        logic [3:0] c;
        c = (e > 4'(MAX_EXTENT)) ? 4'(MAX_EXTENT) : e;
        return IDX_W'(c - 4'd1);
    endfunction

endpackage

>>> rtl/weighted_four_index_contraction.sv
// Top level of the weighted four-index contraction block.
// Holds the A, B, C stores, the weight registers, the shared multiplier
// and its sequencer. Depends on wfic_pkg.
//
//  channel | direction | signals                                   | transaction
//  --------+-----------+-------------------------------------------+-------------------
//  in      | input     | i_in_valid/o_in_ready, cmd, 4 idx, value  | one command
//  out     | output    | o_out_valid/i_out_ready, kind, data, sat  | read data or done
//  cfg     | input     | i_cfg_valid/o_cfg_ready, index, data      | one register write
//
// Loads and unknown commands are taken in IDLE; a read of C passes through RDC and EMIT.
// A run steps through the T_ states for each (p,q) term and the F_ states for each output
// element, then EMIT, all through one 32x32 multiplier; a zero extent goes straight
// from IDLE to EMIT.
// After reset a clearing pass zeroes all 4096 entries of A, B and C; no command
// is taken meanwhile. A stalled result blocks only the next read or run.
module weighted_four_index_contraction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_index_one,
    input  logic [2:0]  i_index_two,
    input  logic [2:0]  i_index_three,
    input  logic [2:0]  i_index_four,
    input  logic signed [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic signed [31:0] o_data,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = wfic_pkg::ADDR_W;
    localparam int IW = wfic_pkg::IDX_W;

    wfic_pkg::t_state r_state, n_state;

    // Configuration
    logic [3:0]  r_ext [6];
    logic signed [31:0] r_scale;

    // Stores
    logic [31:0] a_mem [wfic_pkg::DEPTH];
    logic [31:0] b_mem [wfic_pkg::DEPTH];
    logic [31:0] c_mem [wfic_pkg::DEPTH];
    logic [wfic_pkg::WGT_W-1:0] r_wp [wfic_pkg::MAX_EXTENT];
    logic [wfic_pkg::WGT_W-1:0] r_wq [wfic_pkg::MAX_EXTENT];
    logic        r_sat;

    // Sequencer counters
    logic [AW-1:0] r_clr;
    logic [IW-1:0] r_p, r_q, r_i1, r_i2, r_i3, r_i4;
    logic [IW-1:0] lp_last, lq_last, l1, l2, l3, l4;

    // Datapath
    logic [31:0] a_rd, b_rd, c_rd;
    logic [31:0] op_a, op_b;
    logic [63:0] r_prod;
    logic [16:0] r_w;
    logic        r_xneg;
    logic [46:0] r_xmag;
    logic [63:0] r_tlo;
    logic [46:0] r_tmag;
    logic signed [63:0] r_sum;
    logic [63:0] r_ms;
    logic        r_neg;
    logic [63:0] r_hp;
    logic [33:0] r_mag;

    // Result register
    logic        r_out_valid, r_out_kind, r_out_sat;
    logic [31:0] r_out_data;
    logic        r_res_kind;
    logic [31:0] r_res_data;

    logic accept, zero_ext, out_free;
    logic [AW-1:0] in_addr, a_addr, b_addr, c_addr;
    logic [wfic_pkg::WGT_W-1:0] w_in;
    logic a_we, b_we, c_we;
    logic [31:0] a_wd, b_wd, c_wd;
    logic [AW-1:0] c_waddr;

    // Combinational helpers
    logic [63:0] x_round, t_full, ms_abs, lp_sum, hp_mag;
    logic [33:0] mag_clamp;
    logic [32:0] w_round;
    logic signed [35:0] c_new;
    logic [31:0] c_sat;
    logic        c_ovf;
    logic [31:0] abs_a, abs_b, abs_f;

    assign o_in_ready  = (r_state == wfic_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_data      = r_out_data;
    assign o_saturated = r_out_sat;

    assign lp_last = wfic_pkg::last_idx(r_ext[0]);
    assign lq_last = wfic_pkg::last_idx(r_ext[1]);
    assign l1      = wfic_pkg::last_idx(r_ext[2]);
    assign l2      = wfic_pkg::last_idx(r_ext[3]);
    assign l3      = wfic_pkg::last_idx(r_ext[4]);
    assign l4      = wfic_pkg::last_idx(r_ext[5]);
    assign zero_ext = (r_ext[0] == 4'd0) || (r_ext[1] == 4'd0) || (r_ext[2] == 4'd0)
                   || (r_ext[3] == 4'd0) || (r_ext[4] == 4'd0) || (r_ext[5] == 4'd0);

    assign in_addr = {i_index_one, i_index_two, i_index_three, i_index_four};
    assign a_addr  = {r_p, r_q, r_i1, r_i2};
    assign b_addr  = {r_p, r_q, r_i3, r_i4};
    assign c_addr  = (r_state == wfic_pkg::ST_IDLE) ? in_addr : {r_i1, r_i2, r_i3, r_i4};
    assign w_in    = (i_value[16:0] > wfic_pkg::WEIGHT_ONE) ? wfic_pkg::WEIGHT_ONE
                                                            : i_value[16:0];

    // Store write ports: clearing pass, loads, and C updates of a run
    always_comb begin
        a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
        a_wd = i_value; b_wd = i_value; c_wd = i_value;
        c_waddr = in_addr;
        if (r_state == wfic_pkg::ST_CLEAR) begin
            a_we = 1'b1; b_we = 1'b1; c_we = 1'b1;
            a_wd = '0; b_wd = '0; c_wd = '0;
            c_waddr = r_clr;
        end else if (r_state == wfic_pkg::ST_F_WR) begin
            c_we = 1'b1;
            c_wd = c_sat;
            c_waddr = {r_i1, r_i2, r_i3, r_i4};
        end else if (accept) begin
            a_we = (i_cmd == wfic_pkg::CMD_WR_A);
            b_we = (i_cmd == wfic_pkg::CMD_WR_B);
            c_we = (i_cmd == wfic_pkg::CMD_WR_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_we) a_mem[(r_state == wfic_pkg::ST_CLEAR) ? r_clr : in_addr] <= a_wd;
        a_rd <= a_mem[a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) b_mem[(r_state == wfic_pkg::ST_CLEAR) ? r_clr : in_addr] <= b_wd;
        b_rd <= b_mem[b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) c_mem[c_waddr] <= c_wd;
        c_rd <= c_mem[c_addr];
    end

    // Shared multiplier operand select
    assign abs_a = a_rd[31] ? (~a_rd + 32'd1) : a_rd;
    assign abs_b = b_rd[31] ? (~b_rd + 32'd1) : b_rd;
    assign abs_f = r_scale[31] ? (~r_scale + 32'sd1) : r_scale;
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            wfic_pkg::ST_T_W: begin
                op_a = 32'(r_wp[r_p]);
                op_b = 32'(r_wq[r_q]);
            end
            wfic_pkg::ST_T_X: begin
                op_a = abs_a;
                op_b = abs_b;
            end
            wfic_pkg::ST_T_LO: begin
                op_a = r_xmag[31:0];
                op_b = 32'(r_w);
            end
            wfic_pkg::ST_T_HI: begin
                op_a = 32'(r_xmag[46:32]);
                op_b = 32'(r_w);
            end
            wfic_pkg::ST_F_HI: begin
                // sum is final here; its magnitude is registered at the same edge
                op_a = ms_abs[63:32];
                op_b = abs_f;
            end
            wfic_pkg::ST_F_LO: begin
                op_a = r_ms[31:0];
                op_b = abs_f;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // Rounding, magnitude and saturation helpers
    assign w_round  = (r_prod[32:0] + 33'd32768) >> 16;
    assign x_round  = (r_prod + 64'd32768) >> 16;
    assign t_full   = ({r_prod[31:0], 32'd0} + r_tlo + 64'd32768) >> 16;
    assign ms_abs   = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
    assign lp_sum   = r_prod + 64'd32768;
    assign hp_mag   = (r_hp << 16) + (lp_sum >> 16);
    assign mag_clamp = ((r_hp[63:32] != 32'd0) || (hp_mag > 64'h2_0000_0000))
                     ? 34'h2_0000_0000 : hp_mag[33:0];
    assign c_new    = 36'(signed'(c_rd)) + (r_neg ? -$signed({2'b00, r_mag})
                                                  : $signed({2'b00, r_mag}));
    assign c_ovf    = (c_new > 36'sh0_7FFF_FFFF) || (c_new < -36'sh0_8000_0000);
    assign c_sat    = (c_new > 36'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF
                    : (c_new < -36'sh0_8000_0000) ? 32'h8000_0000 : c_new[31:0];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wfic_pkg::ST_CLEAR;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wfic_pkg::ST_CLEAR: if (r_clr == AW'(wfic_pkg::DEPTH - 1)) n_state = wfic_pkg::ST_IDLE;
            wfic_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == wfic_pkg::CMD_RUN)
                        n_state = zero_ext ? wfic_pkg::ST_EMIT : wfic_pkg::ST_T_RD;
                    else if (i_cmd == wfic_pkg::CMD_RD_C)
                        n_state = wfic_pkg::ST_RDC;
                end
            end
            wfic_pkg::ST_RDC:   n_state = wfic_pkg::ST_EMIT;
            wfic_pkg::ST_EMIT:  if (out_free) n_state = wfic_pkg::ST_IDLE;
            wfic_pkg::ST_T_RD:  n_state = wfic_pkg::ST_T_W;
            wfic_pkg::ST_T_W:   n_state = wfic_pkg::ST_T_X;
            wfic_pkg::ST_T_X:   n_state = wfic_pkg::ST_T_XR;
            wfic_pkg::ST_T_XR:  n_state = wfic_pkg::ST_T_LO;
            wfic_pkg::ST_T_LO:  n_state = wfic_pkg::ST_T_HI;
            wfic_pkg::ST_T_HI:  n_state = wfic_pkg::ST_T_ACC;
            wfic_pkg::ST_T_ACC: n_state = wfic_pkg::ST_T_SUM;
            wfic_pkg::ST_T_SUM:
                n_state = (r_p == lp_last && r_q == lq_last) ? wfic_pkg::ST_F_HI
                                                             : wfic_pkg::ST_T_RD;
            wfic_pkg::ST_F_HI:  n_state = wfic_pkg::ST_F_LO;
            wfic_pkg::ST_F_LO:  n_state = wfic_pkg::ST_F_MAG;
            wfic_pkg::ST_F_MAG: n_state = wfic_pkg::ST_F_WR;
            wfic_pkg::ST_F_WR:
                n_state = (r_i1 == l1 && r_i2 == l2 && r_i3 == l3 && r_i4 == l4)
                        ? wfic_pkg::ST_EMIT : wfic_pkg::ST_T_RD;
            default: n_state = wfic_pkg::ST_CLEAR;
        endcase
    end

    // Control registers: config, weights, counters, flag, result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_ext[k] <= 4'd8;
            r_scale <= 32'sd65536;
            for (int k = 0; k < wfic_pkg::MAX_EXTENT; k++) begin
                r_wp[k] <= '0;
                r_wq[k] <= '0;
            end
            r_sat <= 1'b0;
            r_clr <= '0;
            r_p <= '0; r_q <= '0;
            r_i1 <= '0; r_i2 <= '0; r_i3 <= '0; r_i4 <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    wfic_pkg::REG_P_EXT: r_ext[0] <= i_cfg_data[3:0];
                    wfic_pkg::REG_Q_EXT: r_ext[1] <= i_cfg_data[3:0];
                    wfic_pkg::REG_E1:    r_ext[2] <= i_cfg_data[3:0];
                    wfic_pkg::REG_E2:    r_ext[3] <= i_cfg_data[3:0];
                    wfic_pkg::REG_E3:    r_ext[4] <= i_cfg_data[3:0];
                    wfic_pkg::REG_E4:    r_ext[5] <= i_cfg_data[3:0];
                    wfic_pkg::REG_SCALE: r_scale  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == wfic_pkg::ST_CLEAR) r_clr <= r_clr + AW'(1);

            if (accept && i_cmd == wfic_pkg::CMD_WGT_P) r_wp[i_index_one] <= w_in;
            if (accept && i_cmd == wfic_pkg::CMD_WGT_Q) r_wq[i_index_one] <= w_in;

            if (accept && i_cmd == wfic_pkg::CMD_RUN) begin
                r_p <= '0; r_q <= '0;
                r_i1 <= '0; r_i2 <= '0; r_i3 <= '0; r_i4 <= '0;
            end

            // p innermost, then q
            if (r_state == wfic_pkg::ST_T_SUM) begin
                if (r_p == lp_last) begin
                    r_p <= '0;
                    r_q <= (r_q == lq_last) ? '0 : r_q + IW'(1);
                end else begin
                    r_p <= r_p + IW'(1);
                end
            end

            // Output element order: i1 fastest, i4 slowest
            if (r_state == wfic_pkg::ST_F_WR) begin
                if (c_ovf) r_sat <= 1'b1;
                if (r_i1 != l1) r_i1 <= r_i1 + IW'(1);
                else begin
                    r_i1 <= '0;
                    if (r_i2 != l2) r_i2 <= r_i2 + IW'(1);
                    else begin
                        r_i2 <= '0;
                        if (r_i3 != l3) r_i3 <= r_i3 + IW'(1);
                        else begin
                            r_i3 <= '0;
                            r_i4 <= r_i4 + IW'(1);
                        end
                    end
                end
            end

            // Result slot
            if (r_state == wfic_pkg::ST_EMIT && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == wfic_pkg::ST_EMIT && out_free) begin
            r_out_kind <= r_res_kind;
            r_out_data <= r_res_data;
            r_out_sat  <= r_sat;
        end
        if (accept && i_cmd == wfic_pkg::CMD_RUN) begin
            r_res_kind <= wfic_pkg::KIND_DONE;
            r_res_data <= '0;
            r_sum      <= '0;
        end
        unique case (r_state)
            wfic_pkg::ST_RDC: begin
                r_res_kind <= wfic_pkg::KIND_READ;
                r_res_data <= c_rd;
            end
            wfic_pkg::ST_T_X: begin
                r_w    <= w_round[16:0];
                r_xneg <= a_rd[31] ^ b_rd[31];
            end
            wfic_pkg::ST_T_XR:  r_xmag <= x_round[46:0];
            wfic_pkg::ST_T_HI:  r_tlo  <= r_prod;
            wfic_pkg::ST_T_ACC: r_tmag <= t_full[46:0];
            wfic_pkg::ST_T_SUM:
                r_sum <= r_xneg ? r_sum - $signed(64'(r_tmag)) : r_sum + $signed(64'(r_tmag));
            wfic_pkg::ST_F_HI: begin
                r_ms  <= ms_abs;
                r_neg <= r_sum[63] != r_scale[31];
            end
            wfic_pkg::ST_F_LO:  r_hp <= r_prod;
            wfic_pkg::ST_F_WR:  r_sum <= '0;
            default: ;
        endcase
        if (r_state == wfic_pkg::ST_F_WR) r_res_kind <= wfic_pkg::KIND_DONE;
    end

    // Clamped magnitude is registered in F_MAG, the cycle after the low partial product lands
    always_ff @(posedge i_clk) begin
        if (r_state == wfic_pkg::ST_F_MAG) r_mag <= mag_clamp;
    end

endmodule

>>> dv/weighted_four_index_contraction_test.sv
// Self-checking testbench for the weighted four-index contraction block.
// Predicts every read and run result from its own copy of the stores; uses wfic_pkg.
`timescale 1ns / 1ps

module weighted_four_index_contraction_test;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int         SETTLE     = 40;

    typedef struct packed {
        logic        kind;
        logic [31:0] data;
        logic        sat;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_cmd = '0;
    logic [2:0]  i_index_one = '0;
    logic [2:0]  i_index_two = '0;
    logic [2:0]  i_index_three = '0;
    logic [2:0]  i_index_four = '0;
    logic signed [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_kind;
    logic signed [31:0] o_data;
    logic        o_saturated;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    weighted_four_index_contraction dut (.*);

    // Clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the block state
    logic [wfic_pkg::WGT_W-1:0] wp_mem [wfic_pkg::MAX_EXTENT];
    logic [wfic_pkg::WGT_W-1:0] wq_mem [wfic_pkg::MAX_EXTENT];
    logic [31:0]      a_mem [wfic_pkg::DEPTH];
    logic [31:0]      b_mem [wfic_pkg::DEPTH];
    logic [31:0]      c_mem [wfic_pkg::DEPTH];
    logic             sat_flag;
    logic [3:0]       extent [6];
    logic [31:0]      scale;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    int      hold_left = 0;

    function automatic longint round16(longint x);
        logic [63:0] m;
        if (x >= 0) begin
            m = x;
            return longint'((m + 64'd32768) >> 16);
        end
        m = -x;
        return -longint'((m + 64'd32768) >> 16);
    endfunction

    function automatic int clamp_ext(logic [3:0] e);
        return (e > wfic_pkg::MAX_EXTENT) ? wfic_pkg::MAX_EXTENT : int'(e);
    endfunction

    // C + round(S*F/2^16) with saturation; sets sat_flag
    function automatic logic [31:0] scaled_add(logic [31:0] c, longint s, longint f);
        logic        neg;
        logic [63:0] ms, mf, hp, lp, mag;
        longint      r;
        neg = (s < 0) != (f < 0);
        ms  = (s < 0) ? -s : s;
        mf  = (f < 0) ? -f : f;
        hp  = (ms >> 32) * mf;
        lp  = {32'd0, ms[31:0]} * mf + 64'd32768;
        if (hp >= 64'h1_0000_0000) begin
            r = neg ? -64'sh2_0000_0000 : 64'sh2_0000_0000;
        end else begin
            mag = (hp << 16) + (lp >> 16);
            if (mag > 64'h2_0000_0000) mag = 64'h2_0000_0000;
            r = longint'($signed(c)) + (neg ? -longint'(mag) : longint'(mag));
        end
        if (r > 64'sd2147483647) begin
            sat_flag = 1'b1;
            r = 64'sd2147483647;
        end else if (r < -64'sd2147483648) begin
            sat_flag = 1'b1;
            r = -64'sd2147483648;
        end
        return r[31:0];
    endfunction

    function automatic void contract();
        int np, nq, n1, n2, n3, n4;
        longint sum, w, x;
        logic [wfic_pkg::ADDR_W-1:0] ci;
        np = clamp_ext(extent[0]); nq = clamp_ext(extent[1]);
        n1 = clamp_ext(extent[2]); n2 = clamp_ext(extent[3]);
        n3 = clamp_ext(extent[4]); n4 = clamp_ext(extent[5]);
        for (int i4 = 0; i4 < n4; i4++)
            for (int i3 = 0; i3 < n3; i3++)
                for (int i2 = 0; i2 < n2; i2++)
                    for (int i1 = 0; i1 < n1; i1++) begin
                        sum = 0;
                        ci = {i1[2:0], i2[2:0], i3[2:0], i4[2:0]};
                        for (int q = 0; q < nq; q++)
                            for (int p = 0; p < np; p++) begin
                                w = round16(longint'(wp_mem[p]) * longint'(wq_mem[q]));
                                x = round16(
                                    longint'($signed(a_mem[{p[2:0], q[2:0], i1[2:0], i2[2:0]}]))
                                  * longint'($signed(b_mem[{p[2:0], q[2:0], i3[2:0], i4[2:0]}])));
                                sum += round16(x * w);
                            end
                        c_mem[ci] = scaled_add(c_mem[ci], sum, longint'($signed(scale)));
                    end
    endfunction

    // Update the shadow state for one accepted command, queue its result
    function automatic void predict_command(logic [2:0] cmd,
                                            logic [wfic_pkg::ADDR_W-1:0] addr,
                                            logic [31:0] val);
        logic [wfic_pkg::WGT_W-1:0] w;
        t_result r;
        w = (val[16:0] > wfic_pkg::WEIGHT_ONE) ? wfic_pkg::WEIGHT_ONE : val[16:0];
        case (cmd)
            wfic_pkg::CMD_WGT_P: wp_mem[addr[11:9]] = w;
            wfic_pkg::CMD_WGT_Q: wq_mem[addr[11:9]] = w;
            wfic_pkg::CMD_WR_A:  a_mem[addr] = val;
            wfic_pkg::CMD_WR_B:  b_mem[addr] = val;
            wfic_pkg::CMD_WR_C:  c_mem[addr] = val;
            wfic_pkg::CMD_RUN: begin
                contract();
                r = '{wfic_pkg::KIND_DONE, 32'd0, sat_flag};
                pending_results.push_back(r);
            end
            wfic_pkg::CMD_RD_C: begin
                r = '{wfic_pkg::KIND_READ, c_mem[addr], sat_flag};
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Send one command transaction, with an occasional random gap in front
    task automatic send_command(logic [2:0] cmd, logic [2:0] x1, logic [2:0] x2,
                                logic [2:0] x3, logic [2:0] x4, logic [31:0] val);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_index_one   <= x1;
        i_index_two   <= x2;
        i_index_three <= x3;
        i_index_four  <= x4;
        i_value       <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_command(cmd, {x1, x2, x3, x4}, val);
    endtask

    // Wait until every expected result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == wfic_pkg::REG_SCALE) scale = data;
        else if (idx < wfic_pkg::REG_SCALE) extent[idx] = data[3:0];
    endtask

    task automatic set_extents(logic [3:0] np, logic [3:0] nq, logic [3:0] n1,
                               logic [3:0] n2, logic [3:0] n3, logic [3:0] n4);
        write_register(wfic_pkg::REG_P_EXT, 32'(np));
        write_register(wfic_pkg::REG_Q_EXT, 32'(nq));
        write_register(wfic_pkg::REG_E1, 32'(n1));
        write_register(wfic_pkg::REG_E2, 32'(n2));
        write_register(wfic_pkg::REG_E3, 32'(n3));
        write_register(wfic_pkg::REG_E4, 32'(n4));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
            2:       return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            default: return $urandom_range(0, 32'h1FFFF);
        endcase
    endfunction

    function automatic logic [2:0] pick_index(int n);
        return (n <= 1) ? 3'd0 : 3'($urandom_range(n - 1));
    endfunction

    // Receiver: random stalls plus a counted long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result kind=%0d data=%h sat=%0d",
                             o_kind, o_data, o_saturated);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_kind !== exp_r.kind || o_data !== exp_r.data ||
                    o_saturated !== exp_r.sat) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind=%0d data=%h sat=%0d, got %0d %h %0d",
                                 exp_r.kind, exp_r.data, exp_r.sat,
                                 o_kind, o_data, o_saturated);
                end
            end
        end
    end

    // Extremes of fields, every command, clamped weights, zero extent, saturation
    task automatic test_directed();
        set_extents(4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
        write_register(wfic_pkg::REG_SCALE, 32'h0001_0000);
        send_command(wfic_pkg::CMD_WGT_P, 3'd0, 3'd0, 3'd0, 3'd0, 32'h0001_FFFF);
        send_command(wfic_pkg::CMD_WGT_P, 3'd1, 3'd7, 3'd7, 3'd7, 32'hFFFF_8000);
        send_command(wfic_pkg::CMD_WGT_Q, 3'd0, 3'd0, 3'd0, 3'd0, 32'h0001_0000);
        send_command(wfic_pkg::CMD_WGT_Q, 3'd7, 3'd0, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_command(wfic_pkg::CMD_WR_A, 3'd0, 3'd0, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_command(wfic_pkg::CMD_WR_A, 3'd1, 3'd0, 3'd0, 3'd0, 32'h8000_0000);
        send_command(wfic_pkg::CMD_WR_B, 3'd0, 3'd0, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_command(wfic_pkg::CMD_WR_B, 3'd1, 3'd0, 3'd0, 3'd0, 32'h0000_8000);
        send_command(wfic_pkg::CMD_WR_C, 3'd7, 3'd7, 3'd7, 3'd7, 32'h8000_0000);
        send_command(wfic_pkg::CMD_RD_C, 3'd7, 3'd7, 3'd7, 3'd7, 32'd0);
        send_command(CMD_UNUSED, 3'd7, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        drain();
        // Huge factor drives C past both bounds
        write_register(wfic_pkg::REG_SCALE, 32'h7FFF_FFFF);
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        drain();
        write_register(wfic_pkg::REG_SCALE, 32'h8000_0000);
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        drain();
        // Zero extent: run leaves C alone
        write_register(wfic_pkg::REG_SCALE, 32'd0);
        write_register(wfic_pkg::REG_P_EXT, 32'd0);
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        drain();
    endtask

    // Largest extents, clamped from 15, spread so runs stay short
    task automatic test_extreme_extents();
        write_register(wfic_pkg::REG_SCALE, 32'h0000_4000);
        set_extents(4'd15, 4'd8, 4'd1, 4'd1, 4'd1, 4'd1);
        for (int p = 0; p < wfic_pkg::MAX_EXTENT; p++) begin
            send_command(wfic_pkg::CMD_WGT_P, p[2:0], 3'd0, 3'd0, 3'd0, $urandom);
            send_command(wfic_pkg::CMD_WGT_Q, p[2:0], 3'd0, 3'd0, 3'd0, $urandom);
            send_command(wfic_pkg::CMD_WR_A, p[2:0], 3'($urandom), 3'd0, 3'd0, pick_value());
            send_command(wfic_pkg::CMD_WR_B, p[2:0], 3'($urandom), 3'd0, 3'd0, pick_value());
        end
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        drain();
        set_extents(4'd1, 4'd1, 4'd15, 4'd8, 4'd9, 4'd8);
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd7, 3'd7, 3'd7, 3'd7, 32'd0);
        send_command(wfic_pkg::CMD_RD_C, 3'd3, 3'd5, 3'd1, 3'd6, 32'd0);
        drain();
    endtask

    // One job: configure, load operands, run, read back
    task automatic random_job();
        int np, nq, n1, n2, n3, n4;
        np = $urandom_range(1, 3); nq = $urandom_range(1, 3);
        n1 = $urandom_range(1, 2); n2 = $urandom_range(1, 2);
        n3 = $urandom_range(1, 2); n4 = $urandom_range(1, 2);
        if ($urandom_range(15) == 0) n1 = 0;
        set_extents(4'(np), 4'(nq), 4'(n1), 4'(n2), 4'(n3), 4'(n4));
        case ($urandom_range(7))
            0:       write_register(wfic_pkg::REG_SCALE, $urandom);
            1, 2:    write_register(wfic_pkg::REG_SCALE, 32'h0001_0000);
            default: write_register(wfic_pkg::REG_SCALE,
                                    32'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
        endcase
        for (int p = 0; p < np; p++) send_command(wfic_pkg::CMD_WGT_P, p[2:0], 3'($urandom),
                                                  3'($urandom), 3'($urandom), $urandom);
        for (int q = 0; q < nq; q++) send_command(wfic_pkg::CMD_WGT_Q, q[2:0], 3'($urandom),
                                                  3'($urandom), 3'($urandom), $urandom);
        repeat ($urandom_range(3, 7)) begin
            send_command(wfic_pkg::CMD_WR_A, pick_index(np), pick_index(nq), pick_index(n1),
                         pick_index(n2), pick_value());
            send_command(wfic_pkg::CMD_WR_B, pick_index(np), pick_index(nq), pick_index(n3),
                         pick_index(n4), pick_value());
        end
        // Noise: stray commands anywhere in the index space
        repeat ($urandom_range(0, 2))
            send_command(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                         3'($urandom), $urandom);
        if ($urandom_range(3) == 0)
            send_command(wfic_pkg::CMD_WR_C, pick_index(n1), pick_index(n2), pick_index(n3),
                         pick_index(n4), pick_value());
        send_command(wfic_pkg::CMD_RUN, 3'd0, 3'd0, 3'd0, 3'd0, $urandom);
        repeat ($urandom_range(2, 4))
            send_command(wfic_pkg::CMD_RD_C, pick_index(n1), pick_index(n2), pick_index(n3),
                         pick_index(n4), $urandom);
        drain();
    endtask

    task automatic test_random(int sidle, int ridle, int jobs);
        send_idle = sidle;
        recv_idle = ridle;
        repeat (jobs) random_job();
    endtask

    // Receiver holds off while commands keep coming; then sender waits for all
    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        hold_left = 400;
        repeat (12) begin
            send_command(wfic_pkg::CMD_RD_C, 3'($urandom), 3'($urandom), 3'($urandom),
                         3'($urandom), 32'd0);
            send_command(wfic_pkg::CMD_WR_C, 3'($urandom), 3'($urandom), 3'($urandom),
                         3'($urandom), $urandom);
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < wfic_pkg::MAX_EXTENT; i++) begin
            wp_mem[i] = '0;
            wq_mem[i] = '0;
        end
        for (int i = 0; i < wfic_pkg::DEPTH; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
        end
        for (int i = 0; i < 6; i++) extent[i] = 4'd8;
        scale    = 32'h0001_0000;
        sat_flag = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_extents();
        test_random(24, 57, 15);
        test_backpressure();
        test_random(57, 24, 15);
        test_random(0, 0, 15);
        drain();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/wfic_pkg.sv
rtl/weighted_four_index_contraction.sv
dv/weighted_four_index_contraction_test.sv
